// ----- sv/rspd_pkg.sv -----
`default_nettype none

package rspd_pkg;

    localparam int LEVEL_W             = 9;
    localparam int BYTE_W              = 8;
    localparam int PHASE_TOP_DEFAULT   = 511;
    localparam int GAMMA_DEPTH_DEFAULT = 256;

    typedef enum logic [1:0] {
        REQ_TICK        = 2'd0,
        REQ_SET_COLOR   = 2'd1,
        REQ_LATCH       = 2'd2,
        REQ_TABLE_WRITE = 2'd3
    } req_type_t;

    typedef struct packed {
        req_type_t            req_type;
        logic [BYTE_W-1:0]    red;
        logic [BYTE_W-1:0]    green;
        logic [BYTE_W-1:0]    blue;
        logic [BYTE_W-1:0]    table_index;
        logic [LEVEL_W-1:0]   table_value;
    } req_t;

    typedef struct packed {
        logic red_on;
        logic green_on;
        logic blue_on;
    } rsp_t;

endpackage

`default_nettype wire

// ----- sv/rspd_ram.sv -----
`default_nettype none

module rspd_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- sv/rgb_staggered_pwm_driver_unit.sv -----
`default_nettype none

// Three-pin staggered PWM driver with gamma correction. Each request transaction
// (tick, set color, latch or gamma table write) yields exactly one response
// transaction carrying the pin states; a tick returns the freshly computed pins,
// any other request returns the pins as they stand. One request is taken every
// clock unless stalled; it passes stage and response registers. The gamma table
// is kept in three identical RAM copies, one per color, so a set-color request
// looks up all three bytes in the cycle it is accepted; the registered RAM read
// sets the extra stage. Levels written by set color reach the pins only after a
// latch and the next tick. Gamma entries must be written before they are used.
module rgb_staggered_pwm_driver_unit #(
    parameter int PHASE_TOP   = rspd_pkg::PHASE_TOP_DEFAULT,
    parameter int GAMMA_DEPTH = rspd_pkg::GAMMA_DEPTH_DEFAULT
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_ready,
    input  wire rspd_pkg::req_t req_data,
    output logic                rsp_valid,
    input  wire logic           rsp_ready,
    output rspd_pkg::rsp_t      rsp_data
);

    localparam int LW = rspd_pkg::LEVEL_W;
    localparam int BW = rspd_pkg::BYTE_W;
    localparam int AW = (GAMMA_DEPTH > 1) ? $clog2(GAMMA_DEPTH) : 1;
    localparam int PW = $clog2(PHASE_TOP + 1);
    localparam int CW = ((PW > LW) ? PW : LW) + 1;

    // handshake and stage control
    logic accept;
    logic adv;
    logic fire;

    logic                s_vld_reg;
    rspd_pkg::req_type_t s_type_reg;
    logic [2:0]          s_inr_reg;

    logic           rsp_vld_reg;
    rspd_pkg::rsp_t rsp_data_reg;

    logic [PW-1:0] phase_reg,  phase_next;
    logic [LW-1:0] pend_reg [3];
    logic [LW-1:0] act_reg  [3];
    logic [2:0]    pins_reg,   pins_next;

    logic [LW-1:0] gam_rd [3];
    logic [2:0]    byte_inr;
    logic          wr_en;
    logic [BW-1:0] col_byte [3];

    logic [CW-1:0] ph0, ph1, ph2;
    logic [CW-1:0] lv  [3];

    assign adv       = !rsp_vld_reg || rsp_ready;
    assign req_ready = !s_vld_reg || adv;
    assign accept    = req_valid && req_ready;
    assign fire      = s_vld_reg && adv;

    assign col_byte[0] = req_data.red;
    assign col_byte[1] = req_data.green;
    assign col_byte[2] = req_data.blue;

    assign wr_en = accept && (req_data.req_type == rspd_pkg::REQ_TABLE_WRITE)
                   && ({1'b0, req_data.table_index} < (BW+1)'(GAMMA_DEPTH));

    for (genvar c = 0; c < 3; c++)
    begin : g_gamma
        assign byte_inr[c] = ({1'b0, col_byte[c]} < (BW+1)'(GAMMA_DEPTH));

        rspd_ram #(
            .WIDTH (LW),
            .DEPTH (GAMMA_DEPTH)
        ) u_gamma (
            .clk   (clk),
            .we    (wr_en),
            .waddr (req_data.table_index[AW-1:0]),
            .wdata (req_data.table_value),
            .re    (accept),
            .raddr (col_byte[c][AW-1:0]),
            .rdata (gam_rd[c])
        );
    end

    function automatic logic [CW-1:0] clamp_lvl(input logic [LW-1:0] l);
        logic [CW-1:0] w;
        w = CW'(l);
        return (w > CW'(PHASE_TOP)) ? CW'(PHASE_TOP) : w;
    endfunction

    // move the phase down by a level, wrapping within 1..PHASE_TOP
    function automatic logic [CW-1:0] shift_ph(input logic [CW-1:0] p,
                                               input logic [CW-1:0] l);
        return (p <= l) ? (p + (CW'(PHASE_TOP) - l)) : (p - l);
    endfunction

    always_comb
    begin
        phase_next = (CW'(phase_reg) >= CW'(PHASE_TOP)) ? PW'(1) : (phase_reg + PW'(1));
        for (int c = 0; c < 3; c++)
        begin
            lv[c] = clamp_lvl(act_reg[c]);
        end
        ph0 = CW'(phase_next);
        ph1 = shift_ph(ph0, lv[0]);
        ph2 = shift_ph(ph1, lv[1]);
        pins_next = pins_reg;
        if (s_type_reg == rspd_pkg::REQ_TICK)
        begin
            pins_next[0] = (lv[0] >= ph0);
            pins_next[1] = (lv[1] >= ph1);
            pins_next[2] = (lv[2] >= ph2);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_vld_reg   <= 1'b0;
            rsp_vld_reg <= 1'b0;
            phase_reg   <= '0;
            pins_reg    <= '0;
            for (int c = 0; c < 3; c++)
            begin
                pend_reg[c] <= '0;
                act_reg[c]  <= '0;
            end
        end
        else
        begin
            if (accept)
            begin
                s_vld_reg <= 1'b1;
            end
            else if (adv)
            begin
                s_vld_reg <= 1'b0;
            end

            if (fire)
            begin
                rsp_vld_reg <= 1'b1;
                case (s_type_reg)
                    rspd_pkg::REQ_TICK:
                    begin
                        phase_reg <= phase_next;
                        pins_reg  <= pins_next;
                    end
                    rspd_pkg::REQ_SET_COLOR:
                    begin
                        for (int c = 0; c < 3; c++)
                        begin
                            pend_reg[c] <= s_inr_reg[c] ? gam_rd[c] : '0;
                        end
                    end
                    rspd_pkg::REQ_LATCH:
                    begin
                        for (int c = 0; c < 3; c++)
                        begin
                            act_reg[c] <= pend_reg[c];
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            else if (rsp_ready)
            begin
                rsp_vld_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s_type_reg <= req_data.req_type;
            s_inr_reg  <= byte_inr;
        end
        if (fire)
        begin
            rsp_data_reg.red_on   <= pins_next[0];
            rsp_data_reg.green_on <= pins_next[1];
            rsp_data_reg.blue_on  <= pins_next[2];
        end
    end

    assign rsp_valid = rsp_vld_reg;
    assign rsp_data  = rsp_data_reg;

    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        CW'(phase_reg) <= CW'(PHASE_TOP))
        else $error("phase counter above top");

    a_phase_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && s_type_reg == rspd_pkg::REQ_TICK && CW'(phase_reg) == CW'(PHASE_TOP))
        |=> phase_reg == PW'(1))
        else $error("phase did not wrap to one");

    a_pins_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && s_type_reg != rspd_pkg::REQ_TICK) |=> $stable(pins_reg))
        else $error("pins changed on a non-tick transaction");

    a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
        !req_ready |-> (s_vld_reg && rsp_vld_reg && !rsp_ready))
        else $error("request stalled while a slot was free");

endmodule

`default_nettype wire
